@@ design/hdlc_transmit_framer_core_assert.svh @@
// Assertion macros for the HDLC transmit framer.
// Needs signals clk and rst in the scope where they are used.
`ifndef HDLC_TRANSMIT_FRAMER_CORE_ASSERT_SVH
`define HDLC_TRANSMIT_FRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define HTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HTF_ASSERT_IMP(lbl, ante, cons, msg)
`define HTF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/hdlcf_pkg.sv @@
// Shared types, constants and the CRC-16/X.25 byte fold for the HDLC framer.
// No dependencies.
package hdlcf_pkg;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [7:0]  HDLC_FLAG = 8'h7E;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    KIND_FLAG = 2'd0,
    KIND_DATA = 2'd1,
    KIND_FCS  = 2'd2
  } kind_t;

  // one serialisation job for the back end
  typedef struct packed {
    logic        stuff;  // apply zero insertion
    logic [15:0] bits;   // sent from bit 0 upwards
    logic [4:0]  len;    // 8 or 16
  } cmd_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] byte_in);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ byte_in[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/hdlcf_front.sv @@
// Front end: accepts items, runs the CRC and issues serialisation jobs.
// Depends on hdlcf_pkg.
module hdlcf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_data,
  output logic              push,
  input  logic              push_ready,
  output hdlcf_pkg::cmd_t   push_cmd
);
  import hdlcf_pkg::*;

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic        take;

  assign in_ready = push_ready;
  assign take     = in_valid && push_ready;

  always_comb begin
    crc_next = crc;
    push     = 1'b0;
    push_cmd = '{stuff: 1'b0, bits: 16'h0000, len: 5'd8};
    if (take) begin
      unique case (in_kind)
        KIND_FLAG: begin
          push     = 1'b1;
          push_cmd = '{stuff: 1'b0, bits: {8'h00, HDLC_FLAG}, len: 5'd8};
          crc_next = CRC_INIT;
        end
        KIND_DATA: begin
          push     = 1'b1;
          push_cmd = '{stuff: 1'b1, bits: {8'h00, in_data}, len: 5'd8};
          crc_next = crc_fold(crc, in_data);
        end
        KIND_FCS: begin
          push     = 1'b1;
          push_cmd = '{stuff: 1'b1, bits: ~crc, len: 5'd16};
        end
        default: begin
          // unused kind: swallowed, nothing sent
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

@@ design/hdlcf_fifo.sv @@
// Two-entry job queue between front and back end.
// Depends on hdlcf_pkg.
module hdlcf_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  output logic              wr_ready,
  input  hdlcf_pkg::cmd_t   wr_cmd,
  input  logic              rd_en,
  output logic              rd_valid,
  output hdlcf_pkg::cmd_t   rd_cmd
);
  import hdlcf_pkg::*;

  cmd_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count != QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entry[rd_ptr];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/hdlcf_back.sv @@
// Back end: LSB-first serialiser with zero insertion; one bit per cycle when
// out_ready allows. Depends on hdlcf_pkg and the assertion macro header.
`include "hdlc_transmit_framer_core_assert.svh"
module hdlcf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  hdlcf_pkg::cmd_t   q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_bit,
  output logic              out_last
);
  import hdlcf_pkg::*;

  logic        active, active_next;
  logic [15:0] sh, sh_next;
  logic [4:0]  rem, rem_next;
  logic        stuff_en, stuff_en_next;
  logic        pend, pend_next;
  logic [2:0]  ones, ones_next;
  logic        out_valid_next, out_bit_next, out_last_next;

  logic        adv;
  logic        emit;
  logic        bit_now;
  logic        last_now;
  logic        stuff_hit;

  assign adv = !out_valid || out_ready;

  always_comb begin
    active_next   = active;
    sh_next       = sh;
    rem_next      = rem;
    stuff_en_next = stuff_en;
    pend_next     = pend;
    ones_next     = ones;
    emit          = 1'b0;
    bit_now       = 1'b0;
    last_now      = 1'b0;
    stuff_hit     = 1'b0;

    if (active && adv) begin
      emit = 1'b1;
      if (pend) begin
        // inserted zero straight after the fifth one
        bit_now   = 1'b0;
        pend_next = 1'b0;
        last_now  = (rem == 5'd0);
      end else begin
        bit_now   = sh[0];
        sh_next   = sh >> 1;
        rem_next  = rem - 5'd1;
        stuff_hit = stuff_en && sh[0] && (ones == 3'd4);
        if (stuff_en) begin
          if (!sh[0] || stuff_hit) begin
            ones_next = 3'd0;
          end else begin
            ones_next = ones + 3'd1;
          end
        end
        pend_next = stuff_hit;
        last_now  = (rem == 5'd1) && !stuff_hit;
      end
      if (last_now) active_next = 1'b0;
    end

    q_pop = q_valid && (!active || last_now);
    if (q_pop) begin
      active_next   = 1'b1;
      sh_next       = q_cmd.bits;
      rem_next      = q_cmd.len;
      stuff_en_next = q_cmd.stuff;
      pend_next     = 1'b0;
      if (!q_cmd.stuff) ones_next = 3'd0;  // flag restarts the run
    end
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    out_bit_next   = out_bit;
    out_last_next  = out_last;
    if (emit) begin
      out_valid_next = 1'b1;
      out_bit_next   = bit_now;
      out_last_next  = last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pend      <= 1'b0;
      ones      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      active    <= active_next;
      pend      <= pend_next;
      ones      <= ones_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sh       <= sh_next;
    rem      <= rem_next;
    stuff_en <= stuff_en_next;
    out_bit  <= out_bit_next;
    out_last <= out_last_next;
  end

  `HTF_ASSERT_IMP(a_ones_max, 1'b1, ones <= 3'd4, "ones run above four")
  `HTF_ASSERT_IMP(a_pend_stuff, pend, stuff_en && ones == 3'd0, "stuff pending outside stuffed job")
  `HTF_ASSERT_IMP(a_active_work, active, rem != 5'd0 || pend, "active job with nothing left")
  `HTF_ASSERT_NXT(a_pend_zero, pend && active && adv, out_valid && !out_bit, "stuffed bit not zero")

endmodule

@@ design/hdlc_transmit_framer_core.sv @@
// HDLC transmit framer top level: front end, job queue, bit serialiser.
// Depends on hdlcf_pkg, hdlcf_front, hdlcf_fifo, hdlcf_back.
//
//  channel  dir  tdata             tuser     tlast
//  s_*      in   [7:0] data        [1:0] kind  -
//  m_*      out  [0] line_bit      -           last
//
// One line bit per clock while m_tready is high. A flag is 8 line bits, a
// data byte 8 plus one per inserted zero (up to 10), an FCS item 16 to 20.
// The serialiser sets the rate; a two-entry queue lets the front take items
// while it is busy. Kind 3 is accepted and sends nothing.
// rst is synchronous: CRC to 0xFFFF, ones run to zero, queue and output empty.
// m_tready low holds the output register; the queue then fills and s_tready drops.
module hdlc_transmit_framer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data
  input  logic [1:0] s_tuser,   // [1:0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] line_bit, [7:1] zero
  output logic       m_tlast
);
  import hdlcf_pkg::*;

  logic  push, push_ready;
  cmd_t  push_cmd;
  logic  q_valid, q_pop;
  cmd_t  q_cmd;
  logic  line_bit;

  hdlcf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser),
    .in_data    (s_tdata),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  hdlcf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  hdlcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bit   (line_bit),
    .out_last  (m_tlast)
  );

  assign m_tdata = {7'b0000000, line_bit};

endmodule
